### src/tpb_pkg.sv
package tpb_pkg;

  // Number of packed words collected into one block.
  localparam int BLOCK_WORDS = 16;
  // Width of a slot index inside one block.
  localparam int SLOT_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  // Block buffer address: one bank bit above the slot index.
  localparam int BUF_ADDR_W  = SLOT_W + 1;
  localparam int BUF_DEPTH   = 2 ** BUF_ADDR_W;

  // Queue between the classifier and the block builder.
  localparam int OPQ_DEPTH   = 4;
  localparam int OPQ_PTR_W   = 2;
  // Result queue in front of the output ports.
  localparam int OUTQ_DEPTH  = 4;
  localparam int OUTQ_PTR_W  = 2;

  // Split of one packed data word between the two tokens.
  typedef enum logic [1:0] {
    LAYOUT_SINGLE = 2'd0,
    LAYOUT_20_12  = 2'd1,
    LAYOUT_16_16  = 2'd2,
    LAYOUT_12_20  = 2'd3
  } layout_e;

  // One packed word for the block builder, with its flush flags.
  typedef struct packed {
    logic [31:0] word;
    layout_e     layout;
    logic        close;
    logic        eos;
    logic        lor;
  } op_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [31:0] word;
    logic        is_ctl;
    logic        eob;
    logic        eos;
    logic        lor;
  } res_t;

endpackage

### src/tpb_front.sv
module tpb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [31:0]    token_i,
  input  logic           final_token_i,
  output logic           op_push_o,
  output tpb_pkg::op_t   op_o,
  input  logic           op_full_i
);

  logic                       pend_vld_q, pend_vld_d;
  logic [31:0]                pend_q, pend_d;
  logic                       extra_vld_q, extra_vld_d;
  tpb_pkg::op_t               extra_q, extra_d;
  logic [tpb_pkg::SLOT_W-1:0] fill_q, fill_d;

  logic                       accept;
  logic                       blk_full;
  logic                       a_lt16, a_lt20, a_lt12;
  logic                       t_lt16, t_lt20, t_lt12;
  tpb_pkg::layout_e           layout;
  logic [31:0]                packed_word;

  // A second word for the same token holds off the next transfer until it is handed on.
  assign full   = extra_vld_q | op_full_i;
  assign accept = push & ~full;

  // Range checks on the pending and the new token.
  assign a_lt16 = (pend_q[31:16] == 16'd0);
  assign a_lt20 = (pend_q[31:20] == 12'd0);
  assign a_lt12 = (pend_q[31:12] == 20'd0);
  assign t_lt16 = (token_i[31:16] == 16'd0);
  assign t_lt20 = (token_i[31:20] == 12'd0);
  assign t_lt12 = (token_i[31:12] == 20'd0);

  assign blk_full = (fill_q == tpb_pkg::SLOT_W'(tpb_pkg::BLOCK_WORDS - 1));

  // Pick the first layout that fits both tokens.
  always_comb begin
    if (a_lt16 && t_lt16) begin
      layout      = tpb_pkg::LAYOUT_16_16;
      packed_word = pend_q | {token_i[15:0], 16'd0};
    end else if (a_lt20 && t_lt12) begin
      layout      = tpb_pkg::LAYOUT_20_12;
      packed_word = pend_q | {token_i[11:0], 20'd0};
    end else if (a_lt12 && t_lt20) begin
      layout      = tpb_pkg::LAYOUT_12_20;
      packed_word = pend_q | {token_i[19:0], 12'd0};
    end else begin
      layout      = tpb_pkg::LAYOUT_SINGLE;
      packed_word = pend_q;
    end
  end

  // Turn each token into zero, one or two words for the block builder.
  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    extra_vld_d = extra_vld_q;
    extra_d     = extra_q;
    op_push_o   = 1'b0;
    op_o        = extra_q;
    if (extra_vld_q) begin
      op_push_o = ~op_full_i;
      if (!op_full_i) begin
        extra_vld_d = 1'b0;
      end
    end else if (accept) begin
      if (!pend_vld_q) begin
        if (final_token_i) begin
          op_push_o = 1'b1;
          op_o      = '{word: token_i, layout: tpb_pkg::LAYOUT_SINGLE,
                        close: 1'b1, eos: 1'b1, lor: 1'b1};
        end else begin
          pend_d     = token_i;
          pend_vld_d = 1'b1;
        end
      end else if (layout != tpb_pkg::LAYOUT_SINGLE) begin
        op_push_o  = 1'b1;
        op_o       = '{word: packed_word, layout: layout,
                       close: blk_full | final_token_i, eos: final_token_i,
                       lor: blk_full | final_token_i};
        pend_vld_d = 1'b0;
      end else begin
        op_push_o = 1'b1;
        op_o      = '{word: pend_q, layout: tpb_pkg::LAYOUT_SINGLE,
                      close: blk_full, eos: 1'b0, lor: blk_full & ~final_token_i};
        if (final_token_i) begin
          extra_d     = '{word: token_i, layout: tpb_pkg::LAYOUT_SINGLE,
                          close: 1'b1, eos: 1'b1, lor: 1'b1};
          extra_vld_d = 1'b1;
          pend_vld_d  = 1'b0;
        end else begin
          pend_d = token_i;
        end
      end
    end
  end

  // Track the block fill so that the flush points are known here.
  always_comb begin
    fill_d = fill_q;
    if (op_push_o) begin
      fill_d = op_o.close ? '0 : tpb_pkg::SLOT_W'(fill_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      pend_q      <= '0;
      extra_vld_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      pend_vld_q  <= pend_vld_d;
      pend_q      <= pend_d;
      extra_vld_q <= extra_vld_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    extra_q <= extra_d;
  end

endmodule

### src/tpb_op_fifo.sv
module tpb_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpb_pkg::op_t  data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tpb_pkg::op_t  data_o,
  output logic          empty_o
);

  tpb_pkg::op_t                  mem_q [tpb_pkg::OPQ_DEPTH];
  logic [tpb_pkg::OPQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tpb_pkg::OPQ_PTR_W:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (tpb_pkg::OPQ_PTR_W + 1)'(tpb_pkg::OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/tpb_back.sv
module tpb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpb_pkg::op_t  op_i,
  input  logic          op_empty_i,
  output logic          op_pop_o,
  output logic          empty,
  input  logic          pop,
  output tpb_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    DR_CTRL = 2'b01,
    DR_DATA = 2'b10
  } drain_state_e;

  // Double-buffered block storage: bank bit over slot index.
  logic [31:0]                buf_mem [tpb_pkg::BUF_DEPTH];
  logic [31:0]                rd_data_q;

  // Fill side.
  logic                       wr_bank_q;
  logic [tpb_pkg::SLOT_W-1:0] wr_slot_q;
  logic [31:0]                ctl_acc_q, ctl_acc_d;
  logic [1:0]                 busy_q, busy_d;
  logic [31:0]                bank_ctl_q  [2];
  logic [tpb_pkg::SLOT_W-1:0] bank_last_q [2];
  logic [1:0]                 bank_eos_q, bank_lor_q;
  logic                       op_take, blk_close;

  // Drain side.
  drain_state_e               state_q;
  logic                       rd_bank_q;
  logic [tpb_pkg::SLOT_W-1:0] rd_slot_q;
  logic                       room, issue, rd_en, rd_last, blk_done;
  logic                       iss_vld_q, iss_ctl_q, iss_eob_q, iss_eos_q, iss_lor_q;
  logic [31:0]                iss_ctl_word_q;

  // Result queue.
  tpb_pkg::res_t                  outq_q [tpb_pkg::OUTQ_DEPTH];
  logic [tpb_pkg::OUTQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [tpb_pkg::OUTQ_PTR_W:0]   oq_cnt_q;
  logic                           oq_pop;
  tpb_pkg::res_t                  res_in;

  // Take a word whenever the bank being filled is not waiting to drain.
  assign op_take   = ~op_empty_i & ~busy_q[wr_bank_q];
  assign op_pop_o  = op_take;
  assign blk_close = op_take & op_i.close;
  assign ctl_acc_d = ctl_acc_q | (32'(op_i.layout) << {wr_slot_q, 1'b0});

  // Drain issues only when the result queue can hold everything in flight.
  assign room  = ((tpb_pkg::OUTQ_PTR_W + 2)'(oq_cnt_q) + (tpb_pkg::OUTQ_PTR_W + 2)'(iss_vld_q))
                 < (tpb_pkg::OUTQ_PTR_W + 2)'(tpb_pkg::OUTQ_DEPTH);
  assign issue    = busy_q[rd_bank_q] & room;
  assign rd_en    = issue & (state_q == DR_DATA);
  assign rd_last  = (rd_slot_q == bank_last_q[rd_bank_q]);
  assign blk_done = rd_en & rd_last;

  // A bank becomes busy when its block closes and free once its last word is read.
  always_comb begin
    busy_d = busy_q;
    if (blk_close) begin
      busy_d[wr_bank_q] = 1'b1;
    end
    if (blk_done) begin
      busy_d[rd_bank_q] = 1'b0;
    end
  end

  // Block buffer write and registered read.
  always_ff @(posedge clk_i) begin
    if (op_take) begin
      buf_mem[{wr_bank_q, wr_slot_q}] <= op_i.word;
    end
    if (rd_en) begin
      rd_data_q <= buf_mem[{rd_bank_q, rd_slot_q}];
    end
  end

  // Bank metadata captured when a block closes.
  always_ff @(posedge clk_i) begin
    if (blk_close) begin
      bank_ctl_q[wr_bank_q]  <= ctl_acc_d;
      bank_last_q[wr_bank_q] <= wr_slot_q;
      bank_eos_q[wr_bank_q]  <= op_i.eos;
      bank_lor_q[wr_bank_q]  <= op_i.lor;
    end
  end

  // Fill and drain control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_bank_q <= 1'b0;
      wr_slot_q <= '0;
      ctl_acc_q <= '0;
      busy_q    <= '0;
      state_q   <= DR_CTRL;
      rd_bank_q <= 1'b0;
      rd_slot_q <= '0;
      iss_vld_q <= 1'b0;
    end else begin
      iss_vld_q <= issue;
      busy_q    <= busy_d;
      if (op_take) begin
        if (op_i.close) begin
          wr_bank_q <= ~wr_bank_q;
          wr_slot_q <= '0;
          ctl_acc_q <= '0;
        end else begin
          wr_slot_q <= tpb_pkg::SLOT_W'(wr_slot_q + 1'b1);
          ctl_acc_q <= ctl_acc_d;
        end
      end
      if (issue) begin
        case (state_q)
          DR_CTRL: begin
            state_q   <= DR_DATA;
            rd_slot_q <= '0;
          end
          DR_DATA: begin
            if (rd_last) begin
              rd_bank_q <= ~rd_bank_q;
              state_q   <= DR_CTRL;
            end else begin
              rd_slot_q <= tpb_pkg::SLOT_W'(rd_slot_q + 1'b1);
            end
          end
          default: begin
            state_q <= DR_CTRL;
          end
        endcase
      end
    end
  end

  // Flags of the word in the read stage.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      iss_ctl_q      <= (state_q == DR_CTRL);
      iss_ctl_word_q <= bank_ctl_q[rd_bank_q];
      iss_eob_q      <= (state_q == DR_DATA) & rd_last;
      iss_eos_q      <= (state_q == DR_DATA) & rd_last & bank_eos_q[rd_bank_q];
      iss_lor_q      <= (state_q == DR_DATA) & rd_last & bank_lor_q[rd_bank_q];
    end
  end

  assign res_in = '{word: iss_ctl_q ? iss_ctl_word_q : rd_data_q, is_ctl: iss_ctl_q,
                    eob: iss_eob_q, eos: iss_eos_q, lor: iss_lor_q};

  // Result queue toward the output ports.
  assign empty  = (oq_cnt_q == '0);
  assign res_o  = outq_q[oq_rd_q];
  assign oq_pop = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (iss_vld_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      if (iss_vld_q && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (!iss_vld_q && oq_pop) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_vld_q) begin
      outq_q[oq_wr_q] <= res_in;
    end
  end

endmodule

### src/token_pair_block_packer.sv
// A token that closes a block passes the op queue, a block bank, the read stage and the
// result queue before its control word shows; data words follow at one per cycle while pop
// is held. Throughput: one token per cycle while full is low; each block adds a control word,
// so a long run of unpaired tokens gives 17 results per 16 tokens, and a final token behind
// an unpaired pending token holds off the next transfer, as it hands the builder two words.
// Reset: asynchronous, active low; clears the pending token, both queues and both busy flags.
module token_pair_block_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] token_i,
  input  logic        final_token_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_word_o,
  output logic        is_control_o,
  output logic        end_of_block_o,
  output logic        end_of_stream_o,
  output logic        last_of_run_o
);

  logic          op_push, op_full, op_pop, op_empty;
  tpb_pkg::op_t  op_in, op_out;
  tpb_pkg::res_t res;

  // Pairs tokens and decides where blocks close.
  tpb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .token_i       (token_i),
    .final_token_i (final_token_i),
    .op_push_o     (op_push),
    .op_o          (op_in),
    .op_full_i     (op_full)
  );

  // Decouples classification from block building.
  tpb_op_fifo u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .empty_o (op_empty)
  );

  // Builds blocks in two banks and streams them out.
  tpb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_out),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign out_word_o      = res.word;
  assign is_control_o    = res.is_ctl;
  assign end_of_block_o  = res.eob;
  assign end_of_stream_o = res.eos;
  assign last_of_run_o   = res.lor;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Clock, reset and the ports of the packer.
  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [31:0] tok_in;
  logic        last_tok_in;
  logic        empty;
  logic        pop;
  logic [31:0] res_word;
  logic        res_ctl;
  logic        res_eob;
  logic        res_eos;
  logic        res_lor;

  // Mirror of the packer state, kept by the prediction tasks.
  logic        pend_vld;
  logic [31:0] pend_tok;
  logic [31:0] blk_word [tpb_pkg::BLOCK_WORDS];
  logic [31:0] blk_layouts;
  int          blk_fill;

  // Results of the token being packed, and all results still owed by the block.
  tpb_pkg::res_t step_q [$];
  tpb_pkg::res_t owed_q [$];

  int n_err;
  int n_checked;
  int n_sent;
  int n_rand;
  int n_streams;

  // Receiver stall pattern.
  int stall_mode;
  int stall_left;

  // Values that sit on either side of each packing threshold.
  localparam logic [31:0] EDGE_TOKENS [8] = '{
    32'h0000_0000, 32'h0000_0FFF, 32'h0000_1000, 32'h0000_FFFF,
    32'h0001_0000, 32'h000F_FFFF, 32'h0010_0000, 32'hFFFF_FFFF
  };

  token_pair_block_packer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .token_i        (tok_in),
    .final_token_i  (last_tok_in),
    .empty          (empty),
    .pop            (pop),
    .out_word_o     (res_word),
    .is_control_o   (res_ctl),
    .end_of_block_o (res_eob),
    .end_of_stream_o(res_eos),
    .last_of_run_o  (res_lor)
  );

  // A 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line, up to a limit, and counts every one.
  task automatic report_mismatch(input string msg);
    if (n_err < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    n_err++;
  endtask

  // Adds one packed word and its layout to the current block.
  task automatic append_word(input logic [31:0] word, input tpb_pkg::layout_e lay);
    blk_word[blk_fill] = word;
    blk_layouts |= 32'(lay) << (2 * blk_fill);
    blk_fill++;
  endtask

  // Emits the control word and then every data word of the current block.
  task automatic flush_block(input logic eos);
    tpb_pkg::res_t r;
    r.word   = blk_layouts;
    r.is_ctl = 1'b1;
    r.eob    = 1'b0;
    r.eos    = 1'b0;
    r.lor    = 1'b0;
    step_q   = {step_q, r};
    for (int i = 0; i < blk_fill; i++) begin
      r.word   = blk_word[i];
      r.is_ctl = 1'b0;
      r.eob    = (i == blk_fill - 1);
      r.eos    = (i == blk_fill - 1) && eos;
      step_q   = {step_q, r};
    end
    blk_layouts = '0;
    blk_fill    = 0;
  endtask

  // Works out the results that one accepted token causes.
  task automatic pack_token(input logic [31:0] tok, input logic fin);
    logic [31:0]      a;
    logic [31:0]      pw;
    tpb_pkg::layout_e lay;
    step_q = {};
    if (!pend_vld) begin
      if (fin) begin
        append_word(tok, tpb_pkg::LAYOUT_SINGLE);
        flush_block(1'b1);
      end else begin
        pend_tok = tok;
        pend_vld = 1'b1;
      end
    end else begin
      a = pend_tok;
      // The layouts are tried in a fixed order: 16+16, then 20+12, then 12+20.
      if (a < (32'd1 << 16) && tok < (32'd1 << 16)) begin
        lay = tpb_pkg::LAYOUT_16_16;
        pw  = a | (tok << 16);
      end else if (a < (32'd1 << 20) && tok < (32'd1 << 12)) begin
        lay = tpb_pkg::LAYOUT_20_12;
        pw  = a | (tok << 20);
      end else if (a < (32'd1 << 12) && tok < (32'd1 << 20)) begin
        lay = tpb_pkg::LAYOUT_12_20;
        pw  = a | (tok << 12);
      end else begin
        lay = tpb_pkg::LAYOUT_SINGLE;
        pw  = a;
      end
      append_word(pw, lay);
      if (lay != tpb_pkg::LAYOUT_SINGLE) begin
        pend_vld = 1'b0;
        pend_tok = '0;
        if (blk_fill >= tpb_pkg::BLOCK_WORDS || fin) begin
          flush_block(fin);
        end
      end else begin
        // The pending token goes out alone and the new one takes its place.
        pend_tok = tok;
        if (blk_fill >= tpb_pkg::BLOCK_WORDS) begin
          flush_block(1'b0);
        end
        if (fin) begin
          append_word(tok, tpb_pkg::LAYOUT_SINGLE);
          pend_vld = 1'b0;
          pend_tok = '0;
          flush_block(1'b1);
        end
      end
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].lor = 1'b1;
    end
    owed_q = {owed_q, step_q};
  endtask

  // Offers one token and waits for its transfer; push stays high afterward.
  task automatic send_token(input logic [31:0] tok, input logic fin);
    @(negedge clk);
    push        <= 1'b1;
    tok_in      <= tok;
    last_tok_in <= fin;
    do @(posedge clk); while (full);
    pack_token(tok, fin);
    n_sent++;
  endtask

  // Keeps push low for the given number of cycles.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stops sending until every owed result has been taken.
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
  endtask

  // Draws a token from a mix of size classes and threshold values.
  function automatic logic [31:0] rand_token();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, 32'h0FFF));
      3, 4:    return 32'($urandom_range(0, 32'hFFFF));
      5, 6:    return 32'($urandom_range(0, 32'hF_FFFF));
      7:       return EDGE_TOKENS[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  // A final token with nothing pending is flushed alone.
  task automatic test_lone_final();
    send_token(32'h0000_0000, 1'b1);
    send_token(32'hFFFF_FFFF, 1'b1);
  endtask

  // Each paired layout at the edges of its thresholds.
  task automatic test_layout_pairs();
    send_token(32'h0000_FFFF, 1'b0);
    send_token(32'h0000_FFFF, 1'b0);
    send_token(32'h0001_0000, 1'b0);
    send_token(32'h0000_0FFF, 1'b0);
    send_token(32'h000F_FFFF, 1'b0);
    send_token(32'h0000_0000, 1'b0);
    send_token(32'h0000_0FFF, 1'b0);
    send_token(32'h000F_FFFF, 1'b1);
    drain_results();
  endtask

  // Tokens that cannot be paired, ending with a final token behind a pending one.
  task automatic test_unpaired_tokens();
    send_token(32'h0010_0000, 1'b0);
    send_token(32'h0000_1000, 1'b0);
    send_token(32'h0001_0000, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b1);
    send_token(32'h8000_0000, 1'b0);
    send_token(32'h0000_0000, 1'b1);
  endtask

  // Fifteen single words and a pending token: the final token flushes a full
  // block and then a block of its own, the longest run of results.
  task automatic test_block_full();
    for (int i = 0; i < tpb_pkg::BLOCK_WORDS; i++) begin
      send_token($urandom | 32'h8000_0000, 1'b0);
    end
    send_token($urandom | 32'h0100_0000, 1'b1);
    drain_results();
  endtask

  // Whole streams of random tokens, sent in bursts with random gaps.
  task automatic test_random_streams();
    int len;
    int burst_left;
    burst_left = 0;
    while (n_sent < 310) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 12);
      if (len > 310 - n_sent) begin
        len = 310 - n_sent;
      end
      for (int i = 0; i < len; i++) begin
        if (burst_left == 0) begin
          hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_token(rand_token(), i == len - 1);
        n_rand++;
      end
      n_streams++;
    end
  endtask

  // The receiver changes at random intervals between free flow, random stalls,
  // long stalls and an on/off rhythm.
  always @(negedge clk) begin
    logic pop_next;
    if (!rst_n) begin
      pop_next = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 250);
      end
      stall_left--;
      case (stall_mode)
        0:       pop_next = 1'b1;
        1:       pop_next = $urandom_range(0, 1);
        2:       pop_next = ($urandom_range(0, 7) == 0);
        default: pop_next = stall_left[3];
      endcase
    end
    pop <= pop_next;
  end

  // Each result transfer is checked against the oldest owed result.
  always @(posedge clk) begin : check_results
    tpb_pkg::res_t e;
    if (rst_n && pop && !empty) begin
      n_checked++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result %08h with nothing owed", res_word));
      end else begin
        e = owed_q.pop_front();
        if (res_word !== e.word) begin
          report_mismatch($sformatf("out_word %08h, want %08h", res_word, e.word));
        end
        if (res_ctl !== e.is_ctl) begin
          report_mismatch($sformatf("is_control %b, want %b", res_ctl, e.is_ctl));
        end
        if (res_eob !== e.eob) begin
          report_mismatch($sformatf("end_of_block %b, want %b", res_eob, e.eob));
        end
        if (res_eos !== e.eos) begin
          report_mismatch($sformatf("end_of_stream %b, want %b", res_eos, e.eos));
        end
        if (res_lor !== e.lor) begin
          report_mismatch($sformatf("last_of_run %b, want %b", res_lor, e.lor));
        end
      end
    end
  end

  // Ends a hung run.
  initial begin
    #5_000_000;
    $display("token_pair_block_packer regression: fail");
    $finish;
  end

  // Reset, the tests in turn, and the verdict.
  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    tok_in      = '0;
    last_tok_in = 1'b0;
    pend_vld    = 1'b0;
    pend_tok    = '0;
    blk_layouts = '0;
    blk_fill    = 0;
    n_err       = 0;
    n_checked   = 0;
    n_sent      = 0;
    n_rand      = 0;
    n_streams   = 0;
    stall_mode  = 0;
    stall_left  = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_lone_final();
    test_layout_pairs();
    test_unpaired_tokens();
    test_block_full();
    test_random_streams();

    drain_results();
    repeat (20) @(posedge clk);
    if (owed_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_q.size()));
    end

    $display("Sent %0d tokens, %0d of them in %0d random streams with bursty input.",
             n_sent, n_rand, n_streams);
    $display("Checked %0d result transfers under a shifting stall pattern; %0d mismatches.",
             n_checked, n_err);
    if (n_err == 0) begin
      $display("token_pair_block_packer regression: pass");
    end else begin
      $display("token_pair_block_packer regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
src/tpb_pkg.sv
src/tpb_front.sv
src/tpb_op_fifo.sv
src/tpb_back.sv
src/token_pair_block_packer.sv
tb/sv/testbench.sv
